// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ABU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ABU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/mur_abu_pkg.sv -----
// Types, widths and arithmetic helpers for the Mur absorbing boundary block.
package mur_abu_pkg;

    localparam int PLANE_CELLS = 4096;
    localparam int IDX_W       = $clog2(PLANE_CELLS);
    localparam int CELL_W      = 12;
    localparam int ACT_W       = 2;
    localparam int COEFF_W     = 18;
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int FULL_W      = COEFF_W + DATA_W;
    localparam int PROD_W      = FULL_W - FRAC_W;
    localparam int SUM_W       = PROD_W + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PRE   = 2'd0,
        ACT_POST  = 2'd1,
        ACT_APPLY = 2'd2
    } t_action;

    typedef struct packed {
        logic              adv;
        logic              load_c;
        t_action           a_act;
        logic [CELL_W-1:0] a_cell;
        logic              b_v;
        t_action           b_act;
        logic [CELL_W-1:0] b_cell;
    } t_ctl;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-DATA_W:0] hi;
        hi = s[SUM_W-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            return s[DATA_W-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- rtl/mur_abu_lane.sv -----
// One tangential component: pending store, multiply stage and saturating sum.
module mur_abu_lane (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mur_abu_pkg::t_ctl                        i_ctl,
    input  logic signed [mur_abu_pkg::COEFF_W-1:0]   i_coeff,
    input  logic signed [mur_abu_pkg::DATA_W-1:0]    i_edge,
    input  logic signed [mur_abu_pkg::DATA_W-1:0]    i_inner,
    output logic signed [mur_abu_pkg::DATA_W-1:0]    o_value
);
    import mur_abu_pkg::*;

    logic signed [DATA_W-1:0] r_mem [PLANE_CELLS];
    logic signed [DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] r_fwd_data;
    logic                     r_fwd;
    logic signed [DATA_W-1:0] r_b_inner;
    logic signed [PROD_W-1:0] r_b_prod;
    logic signed [DATA_W-1:0] r_c_val;

    logic signed [DATA_W-1:0] mul_op;
    logic signed [FULL_W-1:0] prod_full;
    logic signed [DATA_W-1:0] pend;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] n_wdata;
    logic                     wr_en;

    assign mul_op    = (i_ctl.a_act == ACT_PRE) ? i_edge : i_inner;
    assign prod_full = i_coeff * mul_op;
    assign pend      = r_fwd ? r_fwd_data : r_rd;

    always_comb begin
        case (i_ctl.b_act)
            ACT_PRE:  sum = SUM_W'(r_b_inner) - SUM_W'(r_b_prod);
            ACT_POST: sum = SUM_W'(pend) + SUM_W'(r_b_prod);
            default:  sum = SUM_W'(pend);
        endcase
    end

    assign n_wdata = sat_data(sum);
    assign wr_en   = i_ctl.adv && i_ctl.b_v
                     && (i_ctl.b_act == ACT_PRE || i_ctl.b_act == ACT_POST);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_ctl.b_cell[IDX_W-1:0]] <= n_wdata;
        end
        if (i_ctl.adv) begin
            r_rd <= r_mem[i_ctl.a_cell[IDX_W-1:0]];
        end
    end

    // write in flight to the cell being read: bypass the stale array word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_ctl.adv) begin
            r_fwd <= wr_en && (i_ctl.b_cell == i_ctl.a_cell);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_fwd_data <= n_wdata;
            r_b_inner  <= i_inner;
            r_b_prod   <= prod_full[FULL_W-1:FRAC_W];
        end
        if (i_ctl.load_c) begin
            r_c_val <= pend;
        end
    end

    assign o_value = r_c_val;

endmodule

// ----- rtl/mur_absorbing_boundary_update.sv -----
// Top level of the first-order Mur absorbing boundary update.
// An apply word passes the input register, the multiply/read registers and the output register to the master side.
// Throughput: one word per cycle; input stalls only while an apply result is blocked.
// Stages: input register, multiply plus pending read, saturating sum plus write-back.
// Reset: synchronous, active low, clears the valid bits and the bypass flag; the pending store is not cleared.
module mur_absorbing_boundary_update (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: cell_req[11:0], coeff_first[29:12], coeff_second[47:30], edge_first[79:48],
    //        edge_second[111:80], inner_first[143:112], inner_second[175:144]
    input  logic [175:0] i_s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: out_cell[11:0], new_edge_first[43:12], new_edge_second[75:44], zero pad
    output logic [79:0]  o_m_tdata
);
    import mur_abu_pkg::*;
    `include "assert_macros.svh"

    logic                      r_a_v;
    t_action                   r_a_act;
    logic [CELL_W-1:0]         r_a_cell;
    logic signed [COEFF_W-1:0] r_a_coeff1, r_a_coeff2;
    logic signed [DATA_W-1:0]  r_a_edge1, r_a_edge2, r_a_inner1, r_a_inner2;
    logic                      r_b_v;
    t_action                   r_b_act;
    logic [CELL_W-1:0]         r_b_cell;
    logic                      r_c_v;
    logic [CELL_W-1:0]         r_c_cell;

    logic                      c_free;
    logic                      b_move;
    logic                      load_c;
    logic                      s_accept;
    t_ctl                      ctl;
    logic signed [DATA_W-1:0]  val1, val2;

    assign c_free   = !r_c_v || i_m_tready;
    assign b_move   = !r_b_v || (r_b_act != ACT_APPLY) || c_free;
    assign load_c   = b_move && r_b_v && (r_b_act == ACT_APPLY);
    assign s_accept = i_s_tvalid && b_move;

    assign o_s_tready = b_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (b_move) begin
                r_a_v <= s_accept;
                r_b_v <= r_a_v;
            end
            if (load_c) begin
                r_c_v <= 1'b1;
            end else if (i_m_tready) begin
                r_c_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_a_act    <= t_action'(i_s_tuser);
            r_a_cell   <= i_s_tdata[11:0];
            r_a_coeff1 <= i_s_tdata[29:12];
            r_a_coeff2 <= i_s_tdata[47:30];
            r_a_edge1  <= i_s_tdata[79:48];
            r_a_edge2  <= i_s_tdata[111:80];
            r_a_inner1 <= i_s_tdata[143:112];
            r_a_inner2 <= i_s_tdata[175:144];
            r_b_act    <= r_a_act;
            r_b_cell   <= r_a_cell;
        end
        if (load_c) begin
            r_c_cell <= r_b_cell;
        end
    end

    always_comb begin
        ctl.adv    = b_move;
        ctl.load_c = load_c;
        ctl.a_act  = r_a_act;
        ctl.a_cell = r_a_cell;
        ctl.b_v    = r_b_v;
        ctl.b_act  = r_b_act;
        ctl.b_cell = r_b_cell;
    end

    mur_abu_lane u_lane_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_coeff (r_a_coeff1),
        .i_edge  (r_a_edge1),
        .i_inner (r_a_inner1),
        .o_value (val1)
    );

    mur_abu_lane u_lane_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_coeff (r_a_coeff2),
        .i_edge  (r_a_edge2),
        .i_inner (r_a_inner2),
        .o_value (val2)
    );

    assign o_m_tvalid = r_c_v;
    assign o_m_tdata  = {4'b0000, val2, val1, r_c_cell};

    `ABU_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !r_a_v && !r_b_v && !r_c_v, "valid bits not cleared by reset")
    `ABU_ASSERT(a_apply_to_out, load_c |=> r_c_v && (r_c_cell == $past(r_b_cell)), "apply word not loaded into output")
    `ABU_ASSERT(a_a_held, r_a_v && !b_move |=> r_a_v && $stable(r_a_cell), "stalled stage lost its word")

endmodule
